@@ hw/rtl/lci_pkg.sv @@
// ----------------------------------------------------------------------------
// lci_pkg
// Shared widths, request/result types and helpers for line_circle_intersection.
// ----------------------------------------------------------------------------
package lci_pkg;

  localparam int CW        = 32;          // coordinate word
  localparam int FRAC_BITS = 16;
  localparam int RW        = CW - 1;      // radius register
  localparam int HW        = CW;          // partial product half word
  localparam int NW        = 2 * CW;      // |c| and n
  localparam int XW        = 4 * CW;      // c^2 and R^2*n
  localparam int QW        = 4 * CW - 2;  // discriminant quarter
  localparam int SW        = QW / 2;      // square root
  localparam int PW        = 3 * CW;      // product magnitudes
  localparam int AW        = PW + 1;      // signed products

  localparam int FRONT_LAT = 5;
  localparam int SOLVE_LAT = 4;
  localparam int DIV_LAT   = CW + 2;
  localparam int LAT       = FRONT_LAT + SW + SOLVE_LAT + DIV_LAT;

  localparam logic [RW-1:0] RADIUS_RESET = RW'(300 << FRAC_BITS);

  typedef struct packed {
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] dir_x;
    logic signed [CW-1:0] dir_y;
  } line_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] first_x;
    logic signed [CW-1:0] first_y;
    logic signed [CW-1:0] second_x;
    logic signed [CW-1:0] second_y;
  } cross_t;

  typedef struct packed {
    logic                 valid;
    logic                 hit;
    logic                 c_neg;
    logic [NW-1:0]        c_mag;
    logic signed [CW-1:0] vx;
    logic signed [CW-1:0] vy;
    logic [NW-1:0]        n;
  } carry_t;

  typedef struct packed {
    logic          neg;
    logic [PW-1:0] mag;
  } lane_t;

  function automatic logic [CW-1:0] abs_w(input logic signed [CW-1:0] v);
    return v[CW-1] ? CW'(-v) : CW'(v);
  endfunction

endpackage

@@ hw/rtl/lci_front.sv @@
// ----------------------------------------------------------------------------
// lci_front
// Cross product, direction norm, c^2 and R^2*n, discriminant and hit test.
// ----------------------------------------------------------------------------
module lci_front import lci_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  line_t         line_in,
  input  logic [RW-1:0] radius,
  output carry_t        cout,
  output logic [QW-1:0] q
);

  logic                 v1;
  logic [NW-1:0]        p1, p2, vxx, vyy;
  logic                 p1_neg, p2_neg;
  logic [2*RW-1:0]      r2_1, r2_2;
  logic signed [CW-1:0] vx1, vy1;

  logic signed [NW+1:0] sp1, sp2, c_s;
  carry_t               c2, c3, c4, c5;

  logic [NW-1:0]        r2e;
  logic [NW-1:0]        cc_ll, cc_lh, cc_hh, rn_ll, rn_lh, rn_hl, rn_hh;
  logic [XW-1:0]        cc, rn;

  // S1
  always_ff @(posedge clk) begin
    p1     <= NW'(abs_w(line_in.point_x)) * NW'(abs_w(line_in.dir_y));
    p2     <= NW'(abs_w(line_in.point_y)) * NW'(abs_w(line_in.dir_x));
    p1_neg <= line_in.point_x[CW-1] ^ line_in.dir_y[CW-1];
    p2_neg <= line_in.point_y[CW-1] ^ line_in.dir_x[CW-1];
    vxx    <= NW'(abs_w(line_in.dir_x)) * NW'(abs_w(line_in.dir_x));
    vyy    <= NW'(abs_w(line_in.dir_y)) * NW'(abs_w(line_in.dir_y));
    r2_1   <= (2*RW)'(radius) * (2*RW)'(radius);
    vx1    <= line_in.dir_x;
    vy1    <= line_in.dir_y;
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
  end

  // S2
  always_comb begin
    sp1 = p1_neg ? -$signed({2'b00, p1}) : $signed({2'b00, p1});
    sp2 = p2_neg ? -$signed({2'b00, p2}) : $signed({2'b00, p2});
    c_s = sp1 - sp2;
  end

  always_ff @(posedge clk) begin
    c2.hit   <= 1'b0;
    c2.c_neg <= c_s[NW+1];
    c2.c_mag <= c_s[NW+1] ? NW'(-c_s) : NW'(c_s);
    c2.vx    <= vx1;
    c2.vy    <= vy1;
    c2.n     <= vxx + vyy;
    r2_2     <= r2_1;
    if (rst) begin
      c2.valid <= 1'b0;
    end else begin
      c2.valid <= v1;
    end
  end

  // S3: 32x32 partial products
  assign r2e = NW'(r2_2);

  always_ff @(posedge clk) begin
    cc_ll <= NW'(c2.c_mag[HW-1:0]) * NW'(c2.c_mag[HW-1:0]);
    cc_lh <= NW'(c2.c_mag[HW-1:0]) * NW'(c2.c_mag[NW-1:HW]);
    cc_hh <= NW'(c2.c_mag[NW-1:HW]) * NW'(c2.c_mag[NW-1:HW]);
    rn_ll <= NW'(r2e[HW-1:0]) * NW'(c2.n[HW-1:0]);
    rn_lh <= NW'(r2e[HW-1:0]) * NW'(c2.n[NW-1:HW]);
    rn_hl <= NW'(r2e[NW-1:HW]) * NW'(c2.n[HW-1:0]);
    rn_hh <= NW'(r2e[NW-1:HW]) * NW'(c2.n[NW-1:HW]);
    if (rst) begin
      c3 <= '0;
    end else begin
      c3 <= c2;
    end
  end

  // S4: partial product sums
  always_ff @(posedge clk) begin
    cc <= (XW'(cc_hh) << NW) + (XW'(cc_lh) << (HW + 1)) + XW'(cc_ll);
    rn <= (XW'(rn_hh) << NW) + ((XW'(rn_lh) + XW'(rn_hl)) << HW) + XW'(rn_ll);
    if (rst) begin
      c4 <= '0;
    end else begin
      c4 <= c3;
    end
  end

  // S5: q = R^2*n - c^2, hit when positive (n == 0 gives rn == 0)
  always_comb begin
    c5     = c4;
    c5.hit = (rn > cc);
  end

  always_ff @(posedge clk) begin
    q <= QW'(rn - cc);
    if (rst) begin
      cout <= '0;
    end else begin
      cout <= c5;
    end
  end

endmodule

@@ hw/rtl/lci_sqrt.sv @@
// ----------------------------------------------------------------------------
// lci_sqrt
// Pipelined integer square root, one root bit per stage, rounded down.
// ----------------------------------------------------------------------------
module lci_sqrt import lci_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  carry_t        cin,
  input  logic [QW-1:0] q,
  output carry_t        cout,
  output logic [SW-1:0] s
);

  carry_t        cr   [0:SW];
  logic [QW-1:0] rem  [0:SW];
  logic [SW-1:0] root [0:SW];

  assign cr[0]   = cin;
  assign rem[0]  = q;
  assign root[0] = '0;

  for (genvar j = 0; j < SW; j++) begin : g_step
    localparam int I = SW - 1 - j;
    logic [QW+1:0] trial;
    logic          take;

    assign trial = ((QW+2)'(root[j]) << (I + 1)) | ((QW+2)'(1) << (2 * I));
    assign take  = (QW+2)'(rem[j]) >= trial;

    always_ff @(posedge clk) begin
      rem[j+1]  <= take ? QW'((QW+2)'(rem[j]) - trial) : rem[j];
      root[j+1] <= root[j] | (take ? (SW'(1) << I) : SW'(0));
      if (rst) begin
        cr[j+1] <= '0;
      end else begin
        cr[j+1] <= cr[j];
      end
    end
  end

  assign cout = cr[SW];
  assign s    = root[SW];

endmodule

@@ hw/rtl/lci_solve.sv @@
// ----------------------------------------------------------------------------
// lci_solve
// Numerators c*vy +/- s*vx and -c*vx +/- s*vy as sign and magnitude.
// ----------------------------------------------------------------------------
module lci_solve import lci_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  carry_t          cin,
  input  logic [SW-1:0]   s,
  output carry_t          cout,
  output lane_t [3:0]     lanes
);

  carry_t               c1, c2, c3;
  logic [HW-1:0]        avx, avy, c_lo, c_hi, s_lo, s_hi;
  logic [NW-1:0]        cvy_l, cvy_h, cvx_l, cvx_h, svx_l, svx_h, svy_l, svy_h;
  logic                 cvy_n, ncvx_n, svx_n, svy_n;
  logic signed [AW-1:0] cvy, ncvx, svx, svy;
  logic signed [AW:0]   acc [4];

  function automatic logic signed [AW-1:0] to_signed(input logic neg,
                                                     input logic [PW-1:0] mag);
    return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  assign avx  = abs_w(cin.vx);
  assign avy  = abs_w(cin.vy);
  assign c_lo = cin.c_mag[HW-1:0];
  assign c_hi = cin.c_mag[NW-1:HW];
  assign s_lo = s[HW-1:0];
  assign s_hi = HW'(s >> HW);

  // T1
  always_ff @(posedge clk) begin
    cvy_l  <= NW'(c_lo) * NW'(avy);
    cvy_h  <= NW'(c_hi) * NW'(avy);
    cvx_l  <= NW'(c_lo) * NW'(avx);
    cvx_h  <= NW'(c_hi) * NW'(avx);
    svx_l  <= NW'(s_lo) * NW'(avx);
    svx_h  <= NW'(s_hi) * NW'(avx);
    svy_l  <= NW'(s_lo) * NW'(avy);
    svy_h  <= NW'(s_hi) * NW'(avy);
    cvy_n  <= cin.c_neg ^ cin.vy[CW-1];
    ncvx_n <= ~(cin.c_neg ^ cin.vx[CW-1]);
    svx_n  <= cin.vx[CW-1];
    svy_n  <= cin.vy[CW-1];
    if (rst) begin
      c1 <= '0;
    end else begin
      c1 <= cin;
    end
  end

  // T2
  always_ff @(posedge clk) begin
    cvy  <= to_signed(cvy_n,  (PW'(cvy_h) << HW) + PW'(cvy_l));
    ncvx <= to_signed(ncvx_n, (PW'(cvx_h) << HW) + PW'(cvx_l));
    svx  <= to_signed(svx_n,  (PW'(svx_h) << HW) + PW'(svx_l));
    svy  <= to_signed(svy_n,  (PW'(svy_h) << HW) + PW'(svy_l));
    if (rst) begin
      c2 <= '0;
    end else begin
      c2 <= c1;
    end
  end

  // T3
  always_ff @(posedge clk) begin
    acc[0] <= (AW+1)'(cvy)  + (AW+1)'(svx);
    acc[1] <= (AW+1)'(ncvx) + (AW+1)'(svy);
    acc[2] <= (AW+1)'(cvy)  - (AW+1)'(svx);
    acc[3] <= (AW+1)'(ncvx) - (AW+1)'(svy);
    if (rst) begin
      c3 <= '0;
    end else begin
      c3 <= c2;
    end
  end

  // T4
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      lanes[k].neg <= acc[k][AW];
      lanes[k].mag <= acc[k][AW] ? PW'(-acc[k]) : PW'(acc[k]);
    end
    if (rst) begin
      cout <= '0;
    end else begin
      cout <= c3;
    end
  end

endmodule

@@ hw/rtl/lci_div.sv @@
// ----------------------------------------------------------------------------
// lci_div
// Pipelined restoring divide of a numerator by n, one quotient bit per stage,
// rounded to nearest (ties away from zero) and clamped to a signed word.
// ----------------------------------------------------------------------------
module lci_div import lci_pkg::*; (
  input  logic                 clk,
  input  lane_t                num,
  input  logic [NW-1:0]        n,
  output logic signed [CW-1:0] coord
);

  logic [PW-1:0] rem [0:CW];
  logic [CW-1:0] quo [0:CW];
  logic [NW-1:0] dn  [0:CW];
  logic          neg [0:CW];
  logic          sat [0:CW];

  logic          up;
  logic [CW:0]   qr, lim, mag_c;

  always_ff @(posedge clk) begin
    rem[0] <= num.mag;
    quo[0] <= '0;
    dn[0]  <= n;
    neg[0] <= num.neg;
    sat[0] <= num.mag >= (PW'(n) << HW);
  end

  for (genvar j = 0; j < CW; j++) begin : g_bit
    localparam int K = CW - 1 - j;
    logic [PW-1:0] dv;
    logic          take;

    assign dv   = PW'(dn[j]) << K;
    assign take = rem[j] >= dv;

    always_ff @(posedge clk) begin
      rem[j+1] <= take ? rem[j] - dv : rem[j];
      quo[j+1] <= quo[j] | (take ? (CW'(1) << K) : CW'(0));
      dn[j+1]  <= dn[j];
      neg[j+1] <= neg[j];
      sat[j+1] <= sat[j];
    end
  end

  always_comb begin
    up    = ((NW+1)'(rem[CW][NW-1:0]) << 1) >= (NW+1)'(dn[CW]);
    qr    = (CW+1)'(quo[CW]) + (CW+1)'(up);
    lim   = neg[CW] ? ((CW+1)'(1) << (CW - 1)) : (((CW+1)'(1) << (CW - 1)) - 1'b1);
    mag_c = (sat[CW] || qr > lim) ? lim : qr;
  end

  always_ff @(posedge clk) begin
    coord <= neg[CW] ? CW'(-mag_c) : CW'(mag_c);
  end

endmodule

@@ hw/rtl/line_circle_intersection.sv @@
// ----------------------------------------------------------------------------
// line_circle_intersection
// Intersects a 2D line (base point, direction) with an origin-centred circle.
//
// Request: start with line_in (point_x/y, dir_x/y, signed Q15.16). busy is
// always low, so a request is taken on any cycle start is high, one per
// cycle, back to back.
// Result: done pulses for one cycle with result: hit, then the crossing with
// the larger line parameter (first_x/y) and the smaller one (second_x/y),
// rounded to nearest and saturated. No hit (tangent, miss or zero direction)
// gives all-zero coordinates. The receiver cannot stall; results simply leave.
// Pipeline: front, square root, solve and divide sections in turn, one result
// per cycle.
// Radius: cfg_we/cfg_wdata write radius (unsigned Q15.16), 300.0 at reset.
// Reset clears all valid bits: requests in flight are dropped.
// ----------------------------------------------------------------------------
module line_circle_intersection import lci_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  line_t         line_in,
  input  logic          cfg_we,
  input  logic [RW-1:0] cfg_wdata,
  output logic          done,
  output cross_t        result
);

  logic [RW-1:0]        radius;
  carry_t               f_c, q_c, s_c;
  logic [QW-1:0]        q;
  logic [SW-1:0]        s;
  lane_t [3:0]          lanes;
  logic signed [CW-1:0] coord [4];
  logic [DIV_LAT-1:0]   vq, hq;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (cfg_we) begin
      radius <= cfg_wdata;
    end
  end

  assign busy = 1'b0;

  lci_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start & ~busy),
    .line_in  (line_in),
    .radius   (radius),
    .cout     (f_c),
    .q        (q)
  );

  lci_sqrt u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .cin  (f_c),
    .q    (q),
    .cout (q_c),
    .s    (s)
  );

  lci_solve u_solve (
    .clk   (clk),
    .rst   (rst),
    .cin   (q_c),
    .s     (s),
    .cout  (s_c),
    .lanes (lanes)
  );

  for (genvar k = 0; k < 4; k++) begin : g_div
    lci_div u_div (
      .clk   (clk),
      .num   (lanes[k]),
      .n     (s_c.n),
      .coord (coord[k])
    );
  end

  always_ff @(posedge clk) begin
    hq <= {hq[DIV_LAT-2:0], s_c.hit};
    if (rst) begin
      vq <= '0;
    end else begin
      vq <= {vq[DIV_LAT-2:0], s_c.valid};
    end
  end

  always_comb begin
    result.hit      = hq[DIV_LAT-1];
    result.first_x  = hq[DIV_LAT-1] ? coord[0] : '0;
    result.first_y  = hq[DIV_LAT-1] ? coord[1] : '0;
    result.second_x = hq[DIV_LAT-1] ? coord[2] : '0;
    result.second_y = hq[DIV_LAT-1] ? coord[3] : '0;
  end

  assign done = vq[DIV_LAT-1];

  a_req_done: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LAT done)
    else $error("request did not produce a result");

  a_done_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without a request");

endmodule
